### design/lzwe_pkg.sv
`timescale 1ns / 1ps
// Package for the 12-bit LZW encoder: item types, controller states and
// fixed code constants. No dependencies.
package lzwe_pkg;

    localparam int BYTE_W        = 8;
    localparam int CODE_W        = 12;
    localparam int FIRST_LEARNED = 256;

    // One raw input byte
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } t_in_item;

    // One emitted code
    typedef struct packed {
        logic [CODE_W-1:0] code_word;
        logic              last_code;
    } t_out_item;

    // Encoder controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HT_CHK,
        ST_DICT_CHK,
        ST_MISS,
        ST_FLUSH
    } t_state;

endpackage

### design/lzw_encoder_12bit.sv
`timescale 1ns / 1ps
// LZW encoder top level: hash-probe controller over a slot table and a
// code-indexed dictionary. Depends on lzwe_pkg, lzwe_ram and lzwe_outq.
//
//  channel | signals                         | moves
//  --------+---------------------------------+------------------------------
//  in      | i_in_valid, o_in_stall, i_in_data  | one raw byte per item
//  out     | o_out_valid, i_out_stall, o_out_data | one code per item
//
// A byte that extends the match passes the idle, slot check and dictionary
// check states. A byte that ends it goes from slot check to miss at an empty
// slot, and through dictionary check first at a slot left over from an older
// stream. Every hash collision adds one slot table read and one dictionary
// read. The first byte of a stream is taken in idle; a final byte adds a flush.
// After reset a clearing pass writes every table slot, with the input stalled.
// Results go through a two-entry queue; the core waits only when it is full.
module lzw_encoder_12bit #(
    parameter int DICT_SIZE = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lzwe_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lzwe_pkg::t_out_item o_out_data
);
    import lzwe_pkg::*;

    localparam int CW       = $clog2(DICT_SIZE);    // internal code width
    localparam int NW       = CW + 1;               // next free code width
    localparam int SW       = CW + 1;               // slot table address width
    localparam int HT_DEPTH = 1 << SW;
    localparam int DD       = DICT_SIZE - FIRST_LEARNED;
    localparam int DA       = $clog2(DD);
    localparam int DW       = CW + BYTE_W + SW;     // {prefix, byte, slot}

    t_state              r_state;
    t_state              n_state;
    logic [SW-1:0]       r_clr;
    logic [SW-1:0]       n_clr;
    logic [NW-1:0]       r_nf;
    logic [NW-1:0]       n_nf;
    logic [CW-1:0]       r_prefix;
    logic [CW-1:0]       n_prefix;
    logic                r_pvalid;
    logic                n_pvalid;
    logic [BYTE_W-1:0]   r_byte;
    logic [BYTE_W-1:0]   n_byte;
    logic                r_eos;
    logic                n_eos;
    logic [SW-1:0]       r_slot;
    logic [SW-1:0]       n_slot;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       n_idx;

    logic                w_accept;
    logic [NW-1:0]       w_nf_idx;
    logic                w_room;
    logic                w_live;
    logic                w_owned;
    logic                w_match;
    logic                w_q_room;
    logic                w_push;
    t_out_item           w_push_item;

    logic                w_ht_we;
    logic [SW-1:0]       w_ht_waddr;
    logic [CW-1:0]       w_ht_wdata;
    logic [SW-1:0]       w_ht_raddr;
    logic [CW-1:0]       w_ht_rdata;
    logic                w_dict_we;
    logic [DA-1:0]       w_dict_waddr;
    logic [DW-1:0]       w_dict_wdata;
    logic [DA-1:0]       w_dict_raddr;
    logic [DW-1:0]       w_dict_rdata;
    logic [SW-1:0]       w_d_slot;
    logic [BYTE_W-1:0]   w_d_byte;
    logic [CW-1:0]       w_d_prefix;

    // Fold prefix and byte into a slot table address
    function automatic logic [SW-1:0] f_hash(input logic [CW-1:0] prefix,
                                             input logic [BYTE_W-1:0] data);
        return SW'(prefix) ^ (SW'(data) << (SW - BYTE_W)) ^
               SW'({data[3:0], data[7:4]});
    endfunction

    // Slot table: slot -> learned index
    lzwe_ram #(.WIDTH(CW), .DEPTH(HT_DEPTH)) u_ht_ram (
        .i_clk   (i_clk),
        .i_we    (w_ht_we),
        .i_waddr (w_ht_waddr),
        .i_wdata (w_ht_wdata),
        .i_raddr (w_ht_raddr),
        .o_rdata (w_ht_rdata)
    );

    // Dictionary: learned index -> {prefix, byte, owning slot}
    lzwe_ram #(.WIDTH(DW), .DEPTH(DD)) u_dict_ram (
        .i_clk   (i_clk),
        .i_we    (w_dict_we),
        .i_waddr (w_dict_waddr),
        .i_wdata (w_dict_wdata),
        .i_raddr (w_dict_raddr),
        .o_rdata (w_dict_rdata)
    );

    lzwe_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_room  (w_q_room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_data)
    );

    // Decode lookup results
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_nf_idx   = r_nf - NW'(FIRST_LEARNED);
    assign w_room     = (r_nf < NW'(DICT_SIZE));
    assign w_live     = ({1'b0, w_ht_rdata} < w_nf_idx);
    assign w_d_slot   = w_dict_rdata[SW-1:0];
    assign w_d_byte   = w_dict_rdata[SW+BYTE_W-1:SW];
    assign w_d_prefix = w_dict_rdata[DW-1:SW+BYTE_W];
    // A slot counts only while the dictionary entry it names points back at it
    assign w_owned    = (w_d_slot == r_slot);
    assign w_match    = w_owned && (w_d_prefix == r_prefix) && (w_d_byte == r_byte);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == {SW{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (r_pvalid) begin
                        n_state = ST_HT_CHK;
                    end else if (i_in_data.end_of_stream) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_HT_CHK: begin
                n_state = w_live ? ST_DICT_CHK : ST_MISS;
            end
            ST_DICT_CHK: begin
                if (w_match) begin
                    n_state = r_eos ? ST_FLUSH : ST_IDLE;
                end else if (w_owned) begin
                    n_state = ST_HT_CHK;
                end else begin
                    n_state = ST_MISS;
                end
            end
            ST_MISS: begin
                if (w_q_room) begin
                    n_state = r_eos ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (w_q_room) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Memory, queue and handshake controls
    always_comb begin
        o_in_stall   = (r_state != ST_IDLE);
        w_ht_we      = 1'b0;
        w_ht_waddr   = r_slot;
        w_ht_wdata   = CW'(w_nf_idx);
        w_ht_raddr   = r_slot + SW'(1);
        w_dict_we    = 1'b0;
        w_dict_waddr = w_nf_idx[DA-1:0];
        w_dict_wdata = {r_prefix, r_byte, r_slot};
        w_dict_raddr = w_ht_rdata[DA-1:0];
        w_push       = 1'b0;
        w_push_item  = '{code_word: CODE_W'(r_prefix), last_code: 1'b0};
        case (r_state)
            ST_CLEAR: begin
                w_ht_we    = 1'b1;
                w_ht_waddr = r_clr;
                w_ht_wdata = {CW{1'b1}};
            end
            ST_IDLE: begin
                w_ht_raddr = f_hash(r_prefix, i_in_data.data_byte);
            end
            ST_MISS: begin
                w_push    = w_q_room;
                w_ht_we   = w_q_room && w_room;
                w_dict_we = w_q_room && w_room;
            end
            ST_FLUSH: begin
                w_push                = w_q_room;
                w_push_item.last_code = 1'b1;
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_clr    = r_clr;
        n_nf     = r_nf;
        n_prefix = r_prefix;
        n_pvalid = r_pvalid;
        n_byte   = r_byte;
        n_eos    = r_eos;
        n_slot   = r_slot;
        n_idx    = r_idx;
        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + SW'(1);
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_byte = i_in_data.data_byte;
                    n_eos  = i_in_data.end_of_stream;
                    n_slot = f_hash(r_prefix, i_in_data.data_byte);
                    if (!r_pvalid) begin
                        n_prefix = CW'(i_in_data.data_byte);
                        n_pvalid = 1'b1;
                    end
                end
            end
            ST_HT_CHK: begin
                n_idx = w_ht_rdata;
            end
            ST_DICT_CHK: begin
                if (w_match) begin
                    n_prefix = r_idx + CW'(FIRST_LEARNED);
                end else if (w_owned) begin
                    n_slot = r_slot + SW'(1);
                end
            end
            ST_MISS: begin
                if (w_q_room) begin
                    n_prefix = CW'(r_byte);
                    if (w_room) begin
                        n_nf = r_nf + NW'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (w_q_room) begin
                    n_nf     = NW'(FIRST_LEARNED);
                    n_prefix = '0;
                    n_pvalid = 1'b0;
                end
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_nf     <= NW'(FIRST_LEARNED);
            r_prefix <= '0;
            r_pvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_nf     <= n_nf;
            r_prefix <= n_prefix;
            r_pvalid <= n_pvalid;
        end
    end

    // Item payload registers
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_eos  <= n_eos;
        r_slot <= n_slot;
        r_idx  <= n_idx;
    end

    // Next free code stays within the learned range
    a_nf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nf >= NW'(FIRST_LEARNED)) && (r_nf <= NW'(DICT_SIZE)))
        else $error("next free code out of range");

    // A dictionary hit always yields a learned code as prefix
    a_hit_learned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DICT_CHK && w_match) |=> (r_prefix >= CW'(FIRST_LEARNED)))
        else $error("hit produced a literal prefix");

    // The final code of a stream returns the encoder to its start state
    a_flush_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_push_item.last_code) |=>
        (!r_pvalid && r_nf == NW'(FIRST_LEARNED)))
        else $error("flush did not restart the dictionary");

    // A slot check follows only a fresh hash read or a collision
    a_probe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HT_CHK) |->
        ($past(r_state) == ST_IDLE || $past(r_state) == ST_DICT_CHK))
        else $error("slot check without a slot read");

endmodule

### design/lzwe_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module lzwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read the array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/lzwe_outq.sv
`timescale 1ns / 1ps
// Two-entry result queue between the encoder core and the output channel.
// Depends on lzwe_pkg for the result item type.
module lzwe_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lzwe_pkg::t_out_item i_item,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_stall,
    output lzwe_pkg::t_out_item o_item
);
    import lzwe_pkg::*;

    t_out_item   r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic        n_wptr;
    logic        n_rptr;
    logic [1:0]  n_count;
    logic        w_pop;

    assign w_pop   = (r_count != 2'd0) && !i_stall;
    assign o_valid = (r_count != 2'd0);
    assign o_room  = (r_count != 2'd2);
    assign o_item  = r_mem[r_rptr];

    // Advance pointers and count
    always_comb begin
        n_wptr  = i_push ? ~r_wptr : r_wptr;
        n_rptr  = w_pop ? ~r_rptr : r_rptr;
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

### bench/tb_lzw_encoder_12bit.sv
`timescale 1ns / 1ps
// Self-checking bench for lzw_encoder_12bit: drives byte streams through the
// stall handshake and checks every emitted code. Depends on lzwe_pkg and the RTL.
module tb_lzw_encoder_12bit;

    import lzwe_pkg::*;

    // Small dictionary: the full case is reached within a short run
    localparam int DICT_SIZE    = 512;
    localparam int IDLE_PCT     = 29;
    localparam int RAND_BYTES   = 320;
    localparam int DRAIN_CYCLES = 40;
    // Clearing pass plus ~700 bytes, each at worst several probes and long
    // output stalls; far below this in any correct run.
    localparam int LIMIT_CYCLES = 1000000;

    // Code predictor and store of pending codes
    class lzw_code_board;
        int              learned_code [int];
        int              next_code;
        int              prefix_code;
        bit              have_prefix;
        t_out_item       pending_codes [$];
        int              mismatches;

        function new();
            mismatches = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            learned_code.delete();
            next_code   = FIRST_LEARNED;
            prefix_code = 0;
            have_prefix = 1'b0;
        endfunction

        function int next_free();
            return next_code;
        endfunction

        function int pending();
            return pending_codes.size();
        endfunction

        function void push_code(int code, bit last);
            t_out_item it;
            it.code_word = code[CODE_W-1:0];
            it.last_code = last;
            pending_codes = {pending_codes, it};
        endfunction

        // Advance the encoder state by one accepted byte
        function void note_input(t_in_item it);
            int pair_key;
            pair_key = prefix_code * 256 + int'(it.data_byte);
            if (!have_prefix) begin
                prefix_code = it.data_byte;
                have_prefix = 1'b1;
            end else if (learned_code.exists(pair_key)) begin
                prefix_code = learned_code[pair_key];
            end else begin
                push_code(prefix_code, 1'b0);
                if (next_code < DICT_SIZE) begin
                    learned_code[pair_key] = next_code;
                    next_code++;
                end
                prefix_code = it.data_byte;
            end
            // Flush the prefix and drop the dictionary on the final byte
            if (it.end_of_stream) begin
                push_code(prefix_code, 1'b1);
                clear_stream();
            end
        endfunction

        // Compare one emitted code with the oldest prediction
        function void check_code(t_out_item got);
            t_out_item want;
            if (pending_codes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected code: code_word=%0d last_code=%0b",
                             got.code_word, got.last_code);
                return;
            end
            want = pending_codes.pop_front();
            if (got.code_word !== want.code_word || got.last_code !== want.last_code) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("code mismatch: expected code_word=%0d last_code=%0b, got %0d %0b",
                             want.code_word, want.last_code, got.code_word, got.last_code);
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    lzw_code_board board = new();
    bit            quiet = 1'b0;
    int            cycle_count = 0;

    lzw_encoder_12bit #(
        .DICT_SIZE (DICT_SIZE)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Check accepted codes and stall the output at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_code(o_out_data);
        i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_lzw_encoder_12bit NOT OK");
            $finish;
        end
    end

    // Offer one byte, hold it until accepted, then feed the predictor
    task automatic send_byte(input logic [7:0] b, input logic eos);
        t_in_item it;
        it.data_byte     = b;
        it.end_of_stream = eos;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        board.note_input(it);
    endtask

    // Send a whole stream, marking its last byte
    task automatic send_stream(input logic [7:0] bytes [$]);
        for (int i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    initial begin
        logic [7:0] bytes [$];
        logic [7:0] sym [4];
        string      phrase;
        int         sent;
        int         extra;
        int         len;
        int         mode;
        int         nsym;
        int         plen;
        int         r;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: lone bytes at both extremes (flush only)
        bytes = '{8'h00};
        send_stream(bytes);
        bytes = '{8'hFF};
        send_stream(bytes);
        // Repeated byte: final byte extends the match, one code at the end
        bytes = '{8'h41, 8'h41, 8'h41, 8'h41, 8'h41};
        send_stream(bytes);
        // Final byte breaks the match: ordinary code plus flush
        bytes = '{8'h00, 8'hFF};
        send_stream(bytes);
        bytes = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
        send_stream(bytes);
        phrase = "TOBEORNOT";
        bytes.delete();
        for (int i = 0; i < phrase.len(); i++)
            bytes = {bytes, phrase[i]};
        send_stream(bytes);

        // Fill the dictionary in one stream, then keep coding past full
        extra = 0;
        while (board.next_free() < DICT_SIZE || extra < 40) begin
            if (board.next_free() >= DICT_SIZE)
                extra++;
            send_byte(8'($urandom_range(255)), 1'b0);
        end
        send_byte(8'($urandom_range(255)), 1'b1);

        // Random streams: mostly repetitive content so matches grow long
        sent = 0;
        while (sent < RAND_BYTES) begin
            quiet = (sent >= 100 && sent < 230);
            r = $urandom_range(99);
            if (r < 8)
                len = 1;
            else if (r < 88)
                len = $urandom_range(2, 40);
            else
                len = $urandom_range(41, 150);
            mode = $urandom_range(2);
            nsym = $urandom_range(1, 4);
            plen = $urandom_range(1, 6);
            for (int i = 0; i < 4; i++)
                sym[i] = 8'($urandom_range(255));
            bytes.delete();
            for (int i = 0; i < len; i++) begin
                if (mode == 0)
                    bytes = {bytes, 8'($urandom_range(255))};
                else if (mode == 1 || i < plen)
                    bytes = {bytes, sym[$urandom_range(nsym - 1)]};
                else if ($urandom_range(99) < 5)
                    bytes = {bytes, 8'($urandom_range(255))};
                else
                    bytes = {bytes, bytes[i - plen]};
            end
            send_stream(bytes);
            sent += len;
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        // Drain outstanding codes, then watch for strays
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0) begin
            $display("tb_lzw_encoder_12bit OK");
        end else begin
            $display("tb_lzw_encoder_12bit NOT OK");
        end
        $finish;
    end

endmodule

### files.f
design/lzwe_pkg.sv
design/lzwe_ram.sv
design/lzwe_outq.sv
design/lzw_encoder_12bit.sv
bench/tb_lzw_encoder_12bit.sv
